FILE: rtl/sensor_frame_receiver_assert.svh
// Assertion macros for the sensor frame receiver checker.
`ifndef SENSOR_FRAME_RECEIVER_ASSERT_SVH
`define SENSOR_FRAME_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfr_pkg.sv
// Shared constants for the sensor frame receiver.
package sfr_pkg;

  localparam int MAX_DATA_BYTES = 16;
  localparam int DATA_IDX_W     = $clog2(MAX_DATA_BYTES);

  localparam logic [7:0] HEADER_BYTE = 8'h5A;
  localparam logic [7:0] LUX_LEN     = 8'd4;
  localparam logic [7:0] ENV_LEN     = 8'd10;
  localparam logic [7:0] DATA_MAX    = 8'(MAX_DATA_BYTES);

  localparam logic [7:0] LUX_TYPE_RESET = 8'd21;
  localparam logic [7:0] ENV_TYPE_RESET = 8'd69;

  localparam logic [1:0] CFG_LUX_TYPE = 2'd0;
  localparam logic [1:0] CFG_ENV_TYPE = 2'd1;

  localparam logic [1:0] ST_LUX      = 2'd0;
  localparam logic [1:0] ST_ENV      = 2'd1;
  localparam logic [1:0] ST_UNSUP    = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef logic [7:0] byte_t;

endpackage

FILE: rtl/sfr_channels.sv
// Valid/ready channel interfaces for received bytes and decoded frames.
interface sfr_in_if;
  import sfr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  byte_t              frame_kind_byte;
  byte_t              frame_len_byte;
  logic [31:0]        lux_value;
  logic signed [15:0] temp_value;
  logic [31:0]        pressure_value;
  logic [15:0]        humidity_value;
  logic signed [15:0] altitude_meters;

  modport source (
    output valid, output status, output frame_kind_byte, output frame_len_byte,
    output lux_value, output temp_value, output pressure_value,
    output humidity_value, output altitude_meters, input ready
  );
  modport sink (
    input valid, input status, input frame_kind_byte, input frame_len_byte,
    input lux_value, input temp_value, input pressure_value,
    input humidity_value, input altitude_meters, output ready
  );
endinterface

FILE: rtl/sensor_frame_receiver.sv
// A result is registered and shows in the cycle after the byte that ends its frame.
// Throughput: one byte per cycle; input stalls only while a result waits with out ready low.
// The frame parser state and buffer write sit between the input handshake and the result register.
// Reset (rst_n low, synchronous): hunt for header, counters and held bytes to zero,
// type codes to 21 and 69, no result pending. The data buffer is not cleared.
module sensor_frame_receiver (
  input  logic              clk,
  input  logic              rst_n,
  sfr_in_if.sink            in_ch,
  sfr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  sfr_pkg::byte_t    cfg_wdata
);
  import sfr_pkg::*;

  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_TYPE  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  byte_t      type_r, type_nxt;
  byte_t      len_r, len_nxt;
  byte_t      taken_r, taken_nxt;
  byte_t      lux_code_r, env_code_r;
  byte_t      store_r [MAX_DATA_BYTES];

  logic       out_valid_r;
  logic [1:0] out_status_r;
  byte_t      out_kind_r, out_len_r;
  logic [31:0] out_lux_r, out_press_r;
  logic [15:0] out_temp_r, out_hum_r, out_alt_r;

  logic        in_acc;
  logic        fire;
  logic [1:0]  res_status;
  byte_t       res_len;
  byte_t       taken_inc;
  byte_t       rx;
  byte_t       view [10];
  logic        store_we;

  assign rx           = in_ch.rx_byte;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign taken_inc    = taken_r + 8'd1;
  assign store_we     = (phase_r == PH_DATA) && (taken_r < DATA_MAX);

  // Bypass the byte being written so the frame's last byte decodes at once.
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      if ((phase_r == PH_DATA) && (taken_r == 8'(i))) begin
        view[i] = rx;
      end else begin
        view[i] = store_r[i];
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    taken_nxt  = taken_r;
    fire       = 1'b0;
    res_status = ST_UNSUP;
    res_len    = len_r;
    case (phase_r)
      PH_HUNT2: begin
        phase_nxt = (rx == HEADER_BYTE) ? PH_TYPE : PH_HUNT1;
      end
      PH_TYPE: begin
        type_nxt  = rx;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = rx;
        res_len   = rx;
        taken_nxt = 8'd0;
        if (rx > DATA_MAX) begin
          fire       = 1'b1;
          res_status = ST_TOO_LONG;
          phase_nxt  = PH_HUNT1;
        end else if (rx == 8'd0) begin
          fire       = 1'b1;
          res_status = ST_UNSUP;
          phase_nxt  = PH_HUNT1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        taken_nxt = taken_inc;
        if (taken_inc >= len_r) begin
          fire      = 1'b1;
          phase_nxt = PH_HUNT1;
          if (type_r == lux_code_r && len_r == LUX_LEN) begin
            res_status = ST_LUX;
          end else if (type_r == env_code_r && len_r == ENV_LEN) begin
            res_status = ST_ENV;
          end else begin
            res_status = ST_UNSUP;
          end
        end
      end
      default: begin
        phase_nxt = (rx == HEADER_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT1;
      type_r     <= 8'd0;
      len_r      <= 8'd0;
      taken_r    <= 8'd0;
      lux_code_r <= LUX_TYPE_RESET;
      env_code_r <= ENV_TYPE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        type_r  <= type_nxt;
        len_r   <= len_nxt;
        taken_r <= taken_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LUX_TYPE: lux_code_r <= cfg_wdata;
          CFG_ENV_TYPE: env_code_r <= cfg_wdata;
          default: ;
        endcase
      end
      out_valid_r <= (out_valid_r && !out_ch.ready) || (in_acc && fire);
    end
  end

  // Data buffer: one entry written per data byte, no reset.
  always_ff @(posedge clk) begin
    if (in_acc && store_we) begin
      store_r[taken_r[DATA_IDX_W-1:0]] <= rx;
    end
  end

  // Result register: load the decoded frame, zero the fields its status does not use.
  always_ff @(posedge clk) begin
    if (in_acc && fire) begin
      out_status_r <= res_status;
      out_kind_r   <= type_r;
      out_len_r    <= res_len;
      out_lux_r    <= (res_status == ST_LUX) ? {view[0], view[1], view[2], view[3]} : 32'd0;
      if (res_status == ST_ENV) begin
        out_temp_r  <= {view[0], view[1]};
        out_press_r <= {view[2], view[3], view[4], view[5]};
        out_hum_r   <= {view[6], view[7]};
        out_alt_r   <= {view[8], view[9]};
      end else begin
        out_temp_r  <= 16'd0;
        out_press_r <= 32'd0;
        out_hum_r   <= 16'd0;
        out_alt_r   <= 16'd0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.frame_kind_byte = out_kind_r;
  assign out_ch.frame_len_byte  = out_len_r;
  assign out_ch.lux_value       = out_lux_r;
  assign out_ch.temp_value      = $signed(out_temp_r);
  assign out_ch.pressure_value  = out_press_r;
  assign out_ch.humidity_value  = out_hum_r;
  assign out_ch.altitude_meters = $signed(out_alt_r);

endmodule

FILE: rtl/sfr_checker.sv
// Port-level checker for the sensor frame receiver, bound to the top level.
`include "sensor_frame_receiver_assert.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_len,
  input logic [31:0] out_lux,
  input logic [15:0] out_temp,
  input logic [31:0] out_press,
  input logic [15:0] out_hum,
  input logic [15:0] out_alt
);
  import sfr_pkg::*;

  `SFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_len) && $stable(out_lux),
    "stalled result changed")

  `SFR_ASSERT_SAME(a_in_stall, !in_ready, out_valid && !out_ready,
    "input stalled without a blocked result")

  `SFR_ASSERT_SAME(a_lux_fields, out_valid && out_status == ST_LUX,
    out_len == LUX_LEN && out_temp == 16'd0 && out_press == 32'd0
      && out_hum == 16'd0 && out_alt == 16'd0,
    "lux result carries environment fields")

  `SFR_ASSERT_SAME(a_env_fields, out_valid && out_status == ST_ENV,
    out_len == ENV_LEN && out_lux == 32'd0,
    "environment result malformed")

  `SFR_ASSERT_SAME(a_too_long, out_valid && out_status == ST_TOO_LONG,
    out_len > DATA_MAX && out_lux == 32'd0 && out_press == 32'd0,
    "too-long result malformed")

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_len    (out_ch.frame_len_byte),
  .out_lux    (out_ch.lux_value),
  .out_temp   (out_ch.temp_value),
  .out_press  (out_ch.pressure_value),
  .out_hum    (out_ch.humidity_value),
  .out_alt    (out_ch.altitude_meters)
);

FILE: sim/testbench.sv
// Self-checking testbench for sensor_frame_receiver: byte streams in, decoded frames checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;

  // Register indexes past the two type codes; the block ignores them.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_KIND,
    TAKE_LEN,
    TAKE_DATA
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]         status;
    byte_t              kind;
    byte_t              len;
    logic [31:0]        lux;
    logic signed [15:0] temp;
    logic [31:0]        press;
    logic [15:0]        hum;
    logic signed [15:0] alt;
  } frame_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  byte_t      cfg_wdata;

  sfr_in_if  in_ch();
  sfr_out_if out_ch();

  sensor_frame_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Frame parser mirror
  parse_phase_e phase_q;
  byte_t        kind_q;
  byte_t        len_q;
  byte_t        taken_q;
  byte_t        payload_q [MAX_DATA_BYTES];
  byte_t        lux_code_q;
  byte_t        env_code_q;

  frame_result_t pending_frames[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int error_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void queue_result(input logic [1:0] status);
    frame_result_t r;
    r = '0;
    r.status = status;
    r.kind   = kind_q;
    r.len    = len_q;
    if (status == ST_LUX) begin
      r.lux = {payload_q[0], payload_q[1], payload_q[2], payload_q[3]};
    end else if (status == ST_ENV) begin
      r.temp  = {payload_q[0], payload_q[1]};
      r.press = {payload_q[2], payload_q[3], payload_q[4], payload_q[5]};
      r.hum   = {payload_q[6], payload_q[7]};
      r.alt   = {payload_q[8], payload_q[9]};
    end
    pending_frames.push_back(r);
  endfunction

  function automatic void close_frame();
    logic [1:0] status;
    status = ST_UNSUP;
    // Length keeps the two kinds apart even when both codes match.
    if (kind_q == lux_code_q && len_q == LUX_LEN) status = ST_LUX;
    else if (kind_q == env_code_q && len_q == ENV_LEN) status = ST_ENV;
    queue_result(status);
    phase_q = HUNT_FIRST;
  endfunction

  function automatic void parse_byte(input byte_t b);
    case (phase_q)
      HUNT_SECOND: phase_q = (b == HEADER_BYTE) ? TAKE_KIND : HUNT_FIRST;
      TAKE_KIND: begin
        kind_q  = b;
        phase_q = TAKE_LEN;
      end
      TAKE_LEN: begin
        len_q   = b;
        taken_q = '0;
        if (b > DATA_MAX) begin
          queue_result(ST_TOO_LONG);
          phase_q = HUNT_FIRST;
        end else if (b == 8'd0) begin
          close_frame();
        end else begin
          phase_q = TAKE_DATA;
        end
      end
      TAKE_DATA: begin
        if (taken_q < DATA_MAX) payload_q[taken_q[DATA_IDX_W-1:0]] = b;
        taken_q = taken_q + 8'd1;
        if (taken_q >= len_q) close_frame();
      end
      default: phase_q = (b == HEADER_BYTE) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endfunction

  function automatic byte_t pick_data_byte();
    case ($urandom_range(0, 9))
      0: return HEADER_BYTE;
      1: return 8'h00;
      2: return 8'hFF;
      3: return 8'h80;
      4: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_header(ref byte_t q[$], input byte_t kind, input byte_t len);
    q.push_back(HEADER_BYTE);
    q.push_back(HEADER_BYTE);
    q.push_back(kind);
    q.push_back(len);
  endfunction

  // Leave valid high on acceptance; the next call or a drain decides what follows.
  task automatic send_byte(input byte_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    parse_byte(b);
  endtask

  task automatic send_seq(input byte_t q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_type_codes(input byte_t lux_code, input byte_t env_code,
                                input bit poke_spare);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LUX_TYPE;
    cfg_wdata <= lux_code;
    @(posedge clk);
    lux_code_q = lux_code;
    cfg_index <= CFG_ENV_TYPE;
    cfg_wdata <= env_code;
    @(posedge clk);
    env_code_q = env_code;
    if (poke_spare) begin
      cfg_index <= CFG_SPARE_A;
      cfg_wdata <= 8'($urandom_range(0, 255));
      @(posedge clk);
      cfg_index <= CFG_SPARE_B;
      cfg_wdata <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic send_random_stream(input int n_items);
    byte_t q[$];
    byte_t kind;
    byte_t len;
    int    counted;
    int    pick;
    int    n_data;
    counted = 0;
    while (counted < n_items) begin
      q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 4))
          0, 1: begin
            kind = lux_code_q;
            len  = LUX_LEN;
          end
          2, 3: begin
            kind = env_code_q;
            len  = ENV_LEN;
          end
          default: begin
            kind = pick_data_byte();
            len  = 8'($urandom_range(0, MAX_DATA_BYTES));
          end
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2: len = 8'($urandom_range(0, MAX_DATA_BYTES));
          3: len = 8'($urandom_range(MAX_DATA_BYTES + 1, 255));
          default: ;
        endcase
        // Bytes after an oversized length go back through the hunt.
        n_data = (len > DATA_MAX) ? $urandom_range(0, 3) : int'(len);
        add_header(q, kind, len);
        repeat (n_data) q.push_back(pick_data_byte());
        counted += q.size();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) q.push_back(pick_data_byte());
      end else if (pick < 92) begin
        kind = 8'($urandom_range(0, 254));
        if (kind >= HEADER_BYTE) kind = kind + 8'd1;
        q.push_back(HEADER_BYTE);
        q.push_back(kind);
        counted += q.size();
      end else begin
        // Cut the frame short; whatever comes next fills it up.
        len = 8'($urandom_range(2, MAX_DATA_BYTES));
        add_header(q, pick_data_byte(), len);
        repeat ($urandom_range(1, len - 1)) q.push_back(pick_data_byte());
        counted += q.size();
      end
      send_seq(q);
    end
  endtask

  task automatic test_frame_formats();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Light frame with header bytes inside the data
    send_seq('{HEADER_BYTE, HEADER_BYTE, LUX_TYPE_RESET, LUX_LEN,
               HEADER_BYTE, 8'h00, 8'hFF, HEADER_BYTE});
    // Environment frame at the top of every field, altitude at its bottom
    send_seq('{HEADER_BYTE, HEADER_BYTE, ENV_TYPE_RESET, ENV_LEN,
               8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00});
    send_seq('{HEADER_BYTE, HEADER_BYTE, LUX_TYPE_RESET, 8'h00});
    send_seq('{HEADER_BYTE, HEADER_BYTE, ENV_TYPE_RESET, DATA_MAX + 8'd1});
    send_seq('{HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, 8'hFF});
    send_seq('{HEADER_BYTE, 8'hA5});
    drain_results();
  endtask

  task automatic test_type_codes();
    set_type_codes(8'h00, 8'hFF, 1'b1);
    send_seq('{HEADER_BYTE, HEADER_BYTE, 8'h00, LUX_LEN, 8'h01, 8'h02, 8'h03, 8'h04});
    send_seq('{HEADER_BYTE, HEADER_BYTE, 8'hFF, ENV_LEN,
               8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF});
    // Old light code no longer matches
    send_seq('{HEADER_BYTE, HEADER_BYTE, LUX_TYPE_RESET, LUX_LEN,
               8'h11, 8'h22, 8'h33, 8'h44});
    send_random_stream(60);
    set_type_codes(HEADER_BYTE, HEADER_BYTE, 1'b0);
    send_random_stream(60);
    set_type_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    send_random_stream(60);
  endtask

  task automatic test_random_traffic();
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 56, 0, 22};
    stall_tab = '{0, 0, 56, 22};
    for (int i = 0; i < 4; i++) begin
      set_type_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      send_idle_pct  = idle_tab[i];
      recv_stall_pct = stall_tab[i];
      send_random_stream(200);
    end
  endtask

  task automatic test_backpressure();
    set_type_codes(LUX_TYPE_RESET, ENV_TYPE_RESET, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Hold the output while zero-length frames keep coming; the input must stall.
    hold_left = 300;
    repeat (40) send_seq('{HEADER_BYTE, HEADER_BYTE, pick_data_byte(), 8'h00});
    drain_results();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    send_random_stream(100);
  endtask

  // Result checker and output ready
  initial begin
    frame_result_t got;
    frame_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.kind   = out_ch.frame_kind_byte;
        got.len    = out_ch.frame_len_byte;
        got.lux    = out_ch.lux_value;
        got.temp   = out_ch.temp_value;
        got.press  = out_ch.pressure_value;
        got.hum    = out_ch.humidity_value;
        got.alt    = out_ch.altitude_meters;
        if (pending_frames.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected result: status %0d kind %02h len %02h",
                     got.status, got.kind, got.len);
        end else begin
          want = pending_frames.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("mismatch exp/act: status %0d/%0d kind %02h/%02h len %02h/%02h",
                       want.status, got.status, want.kind, got.kind, want.len, got.len);
              $display("  lux %08h/%08h temp %0d/%0d press %08h/%08h hum %04h/%04h alt %0d/%0d",
                       want.lux, got.lux, want.temp, got.temp, want.press, got.press,
                       want.hum, got.hum, want.alt, got.alt);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_LUX_TYPE;
    cfg_wdata     <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    error_count    = 0;
    phase_q        = HUNT_FIRST;
    kind_q         = '0;
    len_q          = '0;
    taken_q        = '0;
    lux_code_q     = LUX_TYPE_RESET;
    env_code_q     = ENV_TYPE_RESET;
    foreach (payload_q[i]) payload_q[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_frame_formats();
    test_type_codes();
    test_random_traffic();
    test_backpressure();
    drain_results();

    if (error_count == 0 && pending_frames.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
